// ----- design/smoothed_load_meter_drive_unit_defines.svh -----
// Assertion macros for the load meter drive unit.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef SMOOTHED_LOAD_METER_DRIVE_UNIT_DEFINES_SVH
`define SMOOTHED_LOAD_METER_DRIVE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SLMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/slmd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slmd_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned FracBits = 8;
  localparam int unsigned LevelW   = 16 + FracBits;
  localparam int unsigned CfgIdxW  = 3;

  // Divider: one quotient bit per step over the full level width
  localparam int unsigned DivSteps = LevelW;
  localparam int unsigned StepCntW = $clog2(DivSteps);
  localparam int unsigned DsrW     = 9;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSmoothDiv = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTimeout   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLoadCmd   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHighThr   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMidThr    = 3'd4;

  // Register reset values
  localparam logic [DataW-1:0] RstSmoothDiv = 8'd8;
  localparam logic [DataW-1:0] RstTimeout   = 8'd20;
  localparam logic [DataW-1:0] RstLoadCmd   = 8'd1;
  localparam logic [DataW-1:0] RstHighThr   = 8'd153;
  localparam logic [DataW-1:0] RstMidThr    = 8'd50;

  typedef struct packed {
    logic             has_message;
    logic [DataW-1:0] command_byte;
    logic [DataW-1:0] value_byte;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] pwm_duty;
    logic             red_led;
    logic             green_led;
    logic             timed_out;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [DataW-1:0]   wr_data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- design/slmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface slmd_in_if;
  logic               valid;
  logic               ready;
  slmd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slmd_out_if;
  logic                valid;
  logic                ready;
  slmd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slmd_cfg_if;
  logic              valid;
  logic              ready;
  slmd_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/smoothed_load_meter_drive_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A tick taken while idle runs the 24-step restoring divider, which forms gap /
// divisor one quotient bit a cycle; then the finish state forms the duty (level
// integer part / 257 by compare and subtract) and the LEDs, waits while a result
// is still held, and hands off to the output register; no new tick is taken until then.
// Reset (rst_ni low, async): registers to their defaults, level and target to 0,
// tick count to the default timeout, so the meter starts blanked.

module smoothed_load_meter_drive_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  slmd_cfg_if.sink         cfg_i,
  slmd_in_if.sink          in_i,
  slmd_out_if.source       out_o
);

  // Sequencer codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StGap  = 2'd1;  // divide gap by smoothing divisor
  localparam logic [1:0] StFin  = 2'd2;  // duty and LEDs, hand off to output reg

  localparam int unsigned DW = slmd_pkg::DataW;
  localparam int unsigned LW = slmd_pkg::LevelW;
  localparam int unsigned IW = LW - slmd_pkg::FracBits;
  localparam int unsigned SW = slmd_pkg::StepCntW;
  localparam int unsigned QW = slmd_pkg::DsrW;
  localparam logic [SW-1:0] LastStep = SW'(slmd_pkg::DivSteps - 1);

  logic [1:0] state_q, state_d;
  logic [SW-1:0] step_q, step_d;

  // Config registers
  logic [DW-1:0] smooth_div_q, smooth_div_d;
  logic [DW-1:0] timeout_q, timeout_d;
  logic [DW-1:0] load_cmd_q, load_cmd_d;
  logic [DW-1:0] high_thr_q, high_thr_d;
  logic [DW-1:0] mid_thr_q, mid_thr_d;

  // Meter state
  logic [DW-1:0] target_q, target_d;
  logic [LW-1:0] level_q, level_d;
  logic [DW-1:0] tick_q, tick_d;

  // Per-tick working regs
  logic up_q, up_d;        // level moves upward
  logic blank_q, blank_d;  // this tick is timed out

  // Gap divider: remainder, dividend/quotient shift reg, divisor
  logic [QW-1:0] rem_q, rem_d;
  logic [LW-1:0] dvq_q, dvq_d;
  logic [QW-1:0] dsr_q, dsr_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  slmd_pkg::out_item_t out_q, out_d;

  // Handshake
  logic in_xfer, cfg_xfer, out_free;

  // Accept-time terms
  logic          hit;
  logic [DW-1:0] tgt_new, tick_base;
  logic [DW:0]   tick_next;
  logic          blank_new;
  logic [LW-1:0] goal;
  logic          up_new;

  // Divider step
  logic [QW:0]   rem_sh;
  logic          fits;
  logic [QW:0]   rem_sub;
  logic [QW-1:0] rem_step;
  logic [LW-1:0] dvq_step;
  logic [LW-1:0] level_upd;

  // Duty from the level integer part
  logic [IW-1:0] whole;
  logic [DW-1:0] whole_hi;
  logic [DW-1:0] duty;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign cfg_xfer = cfg_i.valid & cfg_i.ready;
  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  // Load message handling, then count update and timeout test
  assign hit       = in_i.data.has_message & (in_i.data.command_byte == load_cmd_q);
  assign tgt_new   = hit ? in_i.data.value_byte : target_q;
  assign tick_base = hit ? '0 : tick_q;
  assign tick_next = {1'b0, tick_base} + (DW+1)'(1);
  assign blank_new = tick_next >= {1'b0, timeout_q};

  // Target times 257 is the byte repeated; then shifted into fraction units
  assign goal   = LW'({tgt_new, tgt_new}) << slmd_pkg::FracBits;
  assign up_new = level_q < goal;

  // Restoring division step, one quotient bit
  assign rem_sh   = {rem_q, dvq_q[LW-1]};
  assign fits     = rem_sh >= {1'b0, dsr_q};
  assign rem_sub  = rem_sh - {1'b0, dsr_q};
  assign rem_step = fits ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
  assign dvq_step = {dvq_q[LW-2:0], fits};

  // Level after the gap division finishes (quotient is dvq_step)
  assign level_upd = up_q ? (level_q + dvq_step) : (level_q - dvq_step);

  // whole / 257 is the high byte or one less: high byte times 257 is that
  // byte repeated, so one compare picks the quotient
  assign whole    = level_q[LW-1:slmd_pkg::FracBits];
  assign whole_hi = whole[IW-1:DW];
  assign duty     = ({whole_hi, whole_hi} > whole) ? (whole_hi - DW'(1)) : whole_hi;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    smooth_div_d = smooth_div_q;
    timeout_d    = timeout_q;
    load_cmd_d   = load_cmd_q;
    high_thr_d   = high_thr_q;
    mid_thr_d    = mid_thr_q;
    target_d     = target_q;
    level_d      = level_q;
    tick_d       = tick_q;
    up_d         = up_q;
    blank_d      = blank_q;
    rem_d        = rem_q;
    dvq_d        = dvq_q;
    dsr_d        = dsr_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (cfg_xfer) begin
      case (cfg_i.data.reg_index)
        slmd_pkg::RegSmoothDiv: smooth_div_d = cfg_i.data.wr_data;
        slmd_pkg::RegTimeout:   timeout_d    = cfg_i.data.wr_data;
        slmd_pkg::RegLoadCmd:   load_cmd_d   = cfg_i.data.wr_data;
        slmd_pkg::RegHighThr:   high_thr_d   = cfg_i.data.wr_data;
        slmd_pkg::RegMidThr:    mid_thr_d    = cfg_i.data.wr_data;
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          target_d = tgt_new;
          tick_d   = blank_new ? timeout_q : tick_next[DW-1:0];
          blank_d  = blank_new;
          up_d     = up_new;
          dvq_d    = up_new ? (goal - level_q) : (level_q - goal);
          rem_d    = '0;
          // divisor of zero acts as one
          dsr_d    = (smooth_div_q == '0) ? QW'(1) : QW'(smooth_div_q);
          step_d   = '0;
          state_d  = StGap;
        end
      end
      StGap: begin
        rem_d  = rem_step;
        dvq_d  = dvq_step;
        step_d = step_q + SW'(1);
        if (step_q == LastStep) begin
          level_d = level_upd;
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (blank_q) begin
            out_d.pwm_duty  = '0;
            out_d.red_led   = 1'b0;
            out_d.green_led = 1'b0;
            out_d.timed_out = 1'b1;
          end else begin
            // high band first, even if thresholds are out of order
            out_d.pwm_duty  = duty;
            out_d.timed_out = 1'b0;
            if (duty > high_thr_q) begin
              out_d.red_led   = 1'b1;
              out_d.green_led = 1'b1;
            end else if (duty > mid_thr_q) begin
              out_d.red_led   = 1'b1;
              out_d.green_led = 1'b0;
            end else begin
              out_d.red_led   = 1'b0;
              out_d.green_led = 1'b1;
            end
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and meter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      step_q       <= '0;
      smooth_div_q <= slmd_pkg::RstSmoothDiv;
      timeout_q    <= slmd_pkg::RstTimeout;
      load_cmd_q   <= slmd_pkg::RstLoadCmd;
      high_thr_q   <= slmd_pkg::RstHighThr;
      mid_thr_q    <= slmd_pkg::RstMidThr;
      target_q     <= '0;
      level_q      <= '0;
      tick_q       <= slmd_pkg::RstTimeout;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      smooth_div_q <= smooth_div_d;
      timeout_q    <= timeout_d;
      load_cmd_q   <= load_cmd_d;
      high_thr_q   <= high_thr_d;
      mid_thr_q    <= mid_thr_d;
      target_q     <= target_d;
      level_q      <= level_d;
      tick_q       <= tick_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    blank_q <= blank_d;
    rem_q   <= rem_d;
    dvq_q   <= dvq_d;
    dsr_q   <= dsr_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire

// ----- design/slmd_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "smoothed_load_meter_drive_unit_defines.svh"

module slmd_chk (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_i,
  input wire                      out_valid_i,
  input wire                      out_ready_i,
  input wire slmd_pkg::out_item_t out_data_i
);

  // Blanked result shows nothing
  `SLMD_ASSERT_NOW(a_blank_dark, out_valid_i && out_data_i.timed_out, out_data_i.pwm_duty == '0 && !out_data_i.red_led && !out_data_i.green_led, "blanked result drives needle or LEDs")

  // Live result always lights at least one LED
  `SLMD_ASSERT_NOW(a_live_lit, out_valid_i && !out_data_i.timed_out, out_data_i.red_led || out_data_i.green_led, "live result with both LEDs off")

  // One tick at a time: busy right after taking a tick
  `SLMD_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_i, !in_ready_i, "input ready right after a transfer")

  // Stalled result holds
  `SLMD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind smoothed_load_meter_drive_unit slmd_chk u_slmd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
